// ----- rtl/ise_pkg.sv -----
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types, codes and sizes of the interpolation search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

  // Table size and the widths that follow from it
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  // Signed bound: low runs up to the depth, high down to minus one
  localparam int BND_W       = IDX_W + 2;
  localparam int KEY_W       = 32;
  // Dividend of a probe: key offset times index span
  localparam int NUM_W       = KEY_W + IDX_W;
  // Step counter of the serial divider
  localparam int DCNT_W      = $clog2(IDX_W + 1);

  // Fixed field widths
  localparam int ENTRY_IDX_W = 5;
  localparam int POS_W       = 5;
  localparam int CFG_W       = 6;

  // Configuration port
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam logic [CFG_W-1:0] ENTRIES_RESET = 6'd32;
  localparam logic             REG_ENTRIES   = 1'b0;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic signed [KEY_W-1:0]  key_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [KEY_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ise_ram.sv -----
// ----------------------------------------------------------------------------
// ise_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/ise_div.sv -----
// ----------------------------------------------------------------------------
// ise_div
// Restoring divider for the probe offset, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ise_pkg::div_req_t req,
  output ise_pkg::div_rsp_t      rsp
);

  import ise_pkg::*;

  // The quotient never exceeds the index span, so IDX_W bits suffice
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  dsh_r, dsh_nxt;
  logic [IDX_W-1:0]  quot_r, quot_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  // One compare and subtract a step
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.numer;
      dsh_nxt  = NUM_W'(req.denom) << (IDX_W - 1);
      quot_nxt = '0;
      cnt_nxt  = DCNT_W'(IDX_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quot_nxt = (quot_r << 1) | IDX_W'(ge);
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ----- rtl/ise_seq.sv -----
// ----------------------------------------------------------------------------
// ise_seq
// Item sequencer: table writes, and the probe loop of a search over the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ise_pkg::in_item_t          in_item,
  output logic                            out_valid,
  output ise_pkg::out_item_t              out_item,
  input  wire logic [ise_pkg::CFG_W-1:0]  entries,
  output logic                            ram_we,
  output logic [ise_pkg::IDX_W-1:0]       ram_waddr,
  output logic [ise_pkg::KEY_W-1:0]       ram_wdata,
  output logic [ise_pkg::IDX_W-1:0]       ram_raddr,
  input  wire logic [ise_pkg::KEY_W-1:0]  ram_rdata,
  output ise_pkg::div_req_t               div_req,
  input  wire ise_pkg::div_rsp_t          div_rsp
);

  import ise_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HI,
    S_TEST,
    S_MUL,
    S_DIVST,
    S_DWAIT,
    S_PRB,
    S_PCMP
  } state_t;

  state_t                  state_r, state_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [BND_W-1:0] low_r, low_nxt;
  logic signed [BND_W-1:0] high_r, high_nxt;
  logic signed [BND_W-1:0] probe_r, probe_nxt;
  logic signed [KEY_W-1:0] tl_r, tl_nxt;
  logic [KEY_W-1:0]        diff_r, diff_nxt;
  logic [KEY_W-1:0]        denom_r, denom_nxt;
  logic [IDX_W-1:0]        span_r, span_nxt;
  logic [NUM_W-1:0]        numer_r, numer_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic                    accept;
  logic signed [BND_W-1:0] count;
  logic signed [KEY_W-1:0] rd_key;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign rd_key = $signed(ram_rdata);

  // Covered entries, saturated at the table depth
  assign count = (int'(entries) > TABLE_DEPTH) ? BND_W'(TABLE_DEPTH) : BND_W'(entries);

  // Table writes go straight to the RAM in the accept cycle
  assign ram_we    = accept && (in_item.cmd == CMD_WRITE) &&
                     (int'(in_item.entry_index) < TABLE_DEPTH);
  assign ram_waddr = IDX_W'(in_item.entry_index);
  assign ram_wdata = in_item.key_value;

  // Read address per state: low bound, high bound, then the probe
  always_comb begin
    case (state_r)
      S_CHECK: ram_raddr = IDX_W'(low_r);
      S_HI:    ram_raddr = IDX_W'(high_r);
      S_PRB:   ram_raddr = IDX_W'(probe_r);
      default: ram_raddr = IDX_W'(probe_r);
    endcase
  end

  assign div_req.start = (state_r == S_DIVST);
  assign div_req.numer = numer_r;
  assign div_req.denom = denom_r;

  // Search sequencing
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    probe_nxt     = probe_r;
    tl_nxt        = tl_r;
    diff_nxt      = diff_r;
    denom_nxt     = denom_r;
    span_nxt      = span_r;
    numer_nxt     = numer_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_item.cmd == CMD_SEARCH)) begin
          key_nxt   = in_item.key_value;
          low_nxt   = '0;
          high_nxt  = count - BND_W'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // bounds crossed: absent
        if (low_r > high_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        tl_nxt    = rd_key;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        // key outside t[low]..t[high]: absent
        if ((key_r < tl_r) || (key_r > rd_key)) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          state_nxt     = S_IDLE;
        end else if (rd_key == tl_r) begin
          // flat range: probe the low bound
          probe_nxt = low_r;
          state_nxt = S_PRB;
        end else begin
          // both differences are non-negative and fit 32 unsigned bits
          diff_nxt  = key_r - tl_r;
          denom_nxt = rd_key - tl_r;
          span_nxt  = IDX_W'(high_r - low_r);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        numer_nxt = NUM_W'(diff_r) * NUM_W'(span_r);
        state_nxt = S_DIVST;
      end
      S_DIVST: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        // quotient stays within the span, so the probe lies in low..high
        if (div_rsp.done) begin
          probe_nxt = low_r + BND_W'(div_rsp.quot);
          state_nxt = S_PRB;
        end
      end
      S_PRB: begin
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        if (rd_key == key_r) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.found    = 1'b1;
          out_item_nxt.position = POS_W'(probe_r);
          state_nxt             = S_IDLE;
        end else if (rd_key < key_r) begin
          low_nxt   = probe_r + BND_W'(1);
          state_nxt = S_CHECK;
        end else begin
          high_nxt  = probe_r - BND_W'(1);
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    probe_r    <= probe_nxt;
    tl_r       <= tl_nxt;
    diff_r     <= diff_nxt;
    denom_r    <= denom_nxt;
    span_r     <= span_nxt;
    numer_r    <= numer_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/interpolation_search_engine_core.sv -----
// ----------------------------------------------------------------------------
// interpolation_search_engine_core
// Interpolation search over a RAM table of ascending signed 32-bit keys.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A write item stores
// key_value at entry_index directly in the RAM, busy stays low and no result
// follows. A search item raises busy and gives exactly one result, shown for
// a single cycle with out_valid high; the receiver cannot hold it off, so it
// must be captured in that cycle. A search runs one probe after another: each
// probe makes three reads through the single RAM read port and, unless the
// bounds hold equal keys, waits on the serial divider, which yields one
// quotient bit per cycle. Table entries hold nothing useful until written,
// so load entries 0 to entries_in_use-1 before searching. entries_in_use
// sits at byte address 0 of the configuration port; write it only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolation_search_engine_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire ise_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  output ise_pkg::out_item_t                     out_item,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ise_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [ise_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ise_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  import ise_pkg::*;

  logic [CFG_W-1:0] entries_r;
  logic             cfg_wr;
  logic             reg_sel;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_ENTRIES);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_RESET;
    end else if (cfg_wr) begin
      entries_r <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(entries_r) : '0;

  // Key table
  ise_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Probe divider
  ise_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer
  ise_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .entries   (entries_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/ise_checker.sv -----
// ----------------------------------------------------------------------------
// ise_checker
// Port-level assertions on the interpolation search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire ise_pkg::in_item_t              in_item,
  input wire logic                           out_valid,
  input wire ise_pkg::out_item_t             out_item,
  input wire logic                           pready
);

  import ise_pkg::*;

  // A search item keeps the block busy in the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == CMD_SEARCH)) |=> busy)
    else $error("search item did not raise busy");

  // A write item completes at once
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == CMD_WRITE)) |=> !busy)
    else $error("write item held the block busy");

  // Results are single-cycle and never back to back
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |-> (out_item.position == '0))
    else $error("miss with non-zero position");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind interpolation_search_engine_core ise_checker u_chk (.*);

`default_nettype wire
